### rtl/flptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_pkg: shared types and constants of the four-level page table walker
// Field widths, opcode/kind/status/level codes, and the walk state record.
// ----------------------------------------------------------------------------
package flptw_pkg;

	// Physical address width the walker honors (36..52)
	localparam int unsigned PHYS_ADDR_BITS = 52;

	// Field widths
	localparam int unsigned ADDR_W  = 52;
	localparam int unsigned VA_W    = 48;
	localparam int unsigned ROOT_W  = 40;
	localparam int unsigned ENTRY_W = 64;
	localparam int unsigned IDX_W   = 9;

	// Addresses are clipped to the implemented physical width
	localparam logic [ADDR_W-1:0] PA_MASK =
		ADDR_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1);

	// Entry bit positions
	localparam int unsigned BIT_P  = 0;
	localparam int unsigned BIT_PS = 7;

	// Input opcodes
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_RESPONSE  = 1'b1;

	// Result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
	localparam logic [1:0] ST_READ_FAIL   = 2'd2;
	localparam logic [1:0] ST_UNEXPECTED  = 2'd3;

	// Table levels: the level whose entry is awaited
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [VA_W-1:0]    virtual_address;
		logic [ENTRY_W-1:0] read_data;
		logic              read_ok;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic [1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic            active;
		logic [1:0]      level;
		logic [VA_W-1:0] va;
	} walk_state_t;

endpackage
`default_nettype wire

### rtl/flptw_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_chan_if: valid/ready channels of the page table walker
// One interface for incoming beats (requests and read responses), one for
// result beats (read requests and finished translations).
// ----------------------------------------------------------------------------
interface flptw_in_if;
	import flptw_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic [VA_W-1:0]    virtual_address;
	logic [ENTRY_W-1:0] read_data;
	logic               read_ok;

	modport source (output valid, opcode, virtual_address, read_data, read_ok,
		input ready);
	modport sink (input valid, opcode, virtual_address, read_data, read_ok,
		output ready);
endinterface

interface flptw_out_if;
	import flptw_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] address;
	logic [1:0]        status;

	modport source (output valid, kind, address, status, input ready);
	modport sink (input valid, kind, address, status, output ready);
endinterface
`default_nettype wire

### rtl/flptw_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_step: one walk step
// Given the walk state, the root frame and one input beat, forms the result
// beat and the next walk state. Pure field selection and muxing.
// ----------------------------------------------------------------------------
module flptw_step
	import flptw_pkg::*;
(
	input  logic [ROOT_W-1:0] root_frame,
	input  walk_state_t       cur,
	input  in_item_t          item,
	output out_item_t         res,
	output walk_state_t       nxt
);

	logic [1:0]       next_level;
	logic [IDX_W-1:0] next_idx;
	logic [IDX_W-1:0] root_idx;
	logic             present;
	logic             page_size;

	assign next_level = cur.level + 2'd1;
	assign root_idx   = item.virtual_address[47:39];
	assign present    = item.read_data[BIT_P];
	assign page_size  = item.read_data[BIT_PS];

	// Table index for the level that comes next
	always_comb begin
		unique case (next_level)
			LVL_PML4: next_idx = cur.va[47:39];
			LVL_PDPT: next_idx = cur.va[38:30];
			LVL_PD:   next_idx = cur.va[29:21];
			LVL_PT:   next_idx = cur.va[20:12];
			default:  next_idx = cur.va[47:39];
		endcase
	end

	// Step decision
	always_comb begin
		nxt         = cur;
		res.kind    = KIND_DONE;
		res.address = '0;
		res.status  = ST_UNEXPECTED;
		if (item.opcode == OP_TRANSLATE) begin
			if (!cur.active) begin
				nxt.active  = 1'b1;
				nxt.level   = LVL_PML4;
				nxt.va      = item.virtual_address;
				res.kind    = KIND_READ;
				res.address = {root_frame, root_idx, 3'b000} & PA_MASK;
				res.status  = ST_OK;
			end
		end else if (cur.active) begin
			if (!item.read_ok) begin
				nxt.active = 1'b0;
				res.status = ST_READ_FAIL;
			end else if (!present) begin
				nxt.active = 1'b0;
				res.status = ST_NOT_PRESENT;
			end else if (cur.level == LVL_PDPT && page_size) begin
				// 1 GB page
				nxt.active  = 1'b0;
				res.address = {item.read_data[51:30], cur.va[29:0]} & PA_MASK;
				res.status  = ST_OK;
			end else if (cur.level == LVL_PD && page_size) begin
				// 2 MB page
				nxt.active  = 1'b0;
				res.address = {item.read_data[51:21], cur.va[20:0]} & PA_MASK;
				res.status  = ST_OK;
			end else if (cur.level == LVL_PT) begin
				// 4 KB page
				nxt.active  = 1'b0;
				res.address = {item.read_data[51:12], cur.va[11:0]} & PA_MASK;
				res.status  = ST_OK;
			end else begin
				// descend one level
				nxt.level   = next_level;
				res.kind    = KIND_READ;
				res.address = {item.read_data[51:12], next_idx, 3'b000} & PA_MASK;
				res.status  = ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/four_level_page_table_walker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top: x86-64 four-level page table walker
// Input register, one step of walk logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries translate requests (opcode 0, virtual_address) and memory
//   read responses (opcode 1, read_data, read_ok). Every cmd beat yields
//   exactly one result beat: a read request (kind 0) for the next table
//   entry, or a finished translation (kind 1) with its status.
//   root_frame_we/root_frame_wdata load the PML4 frame number; write it only
//   while no beat is in flight.
//   A result beat passes the input register, then the result register,
//   after its cmd beat is taken. Throughput: one beat per cycle while the
//   result sink does not stall; the walk step is a single pass of field
//   selection between the two registers, so the pace of a walk is set by
//   the memory round trip.
//   Reset (arst_n low) clears the root frame, the walk state and both
//   register valids; the block is idle and ready at once.
//   When the result sink stalls, the result register holds, the input
//   register fills, and cmd.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
	import flptw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              root_frame_we,
	input  logic [ROOT_W-1:0] root_frame_wdata,
	flptw_in_if.sink          cmd,
	flptw_out_if.source       result
);

	logic [ROOT_W-1:0] root_frame_q;
	logic              valid_s1;
	in_item_t          item_s1;
	logic              out_valid_q;
	out_item_t         out_q;
	walk_state_t       walk_q;
	walk_state_t       walk_nxt;
	out_item_t         step_res;
	logic              out_free;
	logic              advance;

	// Handshake
	assign out_free  = !out_valid_q || result.ready;
	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	// Root frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (root_frame_we) begin
			root_frame_q <= root_frame_wdata;
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode          <= cmd.opcode;
			item_s1.virtual_address <= cmd.virtual_address;
			item_s1.read_data       <= cmd.read_data;
			item_s1.read_ok         <= cmd.read_ok;
		end
	end

	flptw_step u_step (
		.root_frame (root_frame_q),
		.cur        (walk_q),
		.item       (item_s1),
		.res        (step_res),
		.nxt        (walk_nxt)
	);

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (advance) begin
			walk_q <= walk_nxt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.kind    = out_q.kind;
	assign result.address = out_q.address;
	assign result.status  = out_q.status;

	// A read request always keeps a walk running
	a_read_keeps_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.kind == KIND_READ) |=> walk_q.active)
		else $error("read request issued but walk not active");

	// A finished or faulted walk leaves the walker idle
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.kind == KIND_DONE && step_res.status != ST_UNEXPECTED)
		|=> !walk_q.active)
		else $error("walk still active after completion");

	// An unexpected beat leaves the walk state untouched
	a_unexpected_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.status == ST_UNEXPECTED) |=> $stable(walk_q))
		else $error("unexpected beat changed walk state");

	// Fault beats carry a zero address, read requests carry ok status
	a_fault_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK)
		|-> (out_q.address == '0 && out_q.kind == KIND_DONE))
		else $error("fault beat with address or read kind");

	// Input stall only with a full input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled without backlog");

endmodule
`default_nettype wire
